// File: design/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared codes, field widths and structures of the send descriptor decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdd_pkg;

  localparam int unsigned DescW   = 32;
  localparam int unsigned TargetW = 2;
  localparam int unsigned OpW     = 5;
  localparam int unsigned SurfW   = 8;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned ElemW   = 9;
  localparam int unsigned CountW  = 5;
  localparam int unsigned AttrW   = 7;
  localparam int unsigned ImmW    = 17;
  localparam int unsigned MsgTypeW = 5;

  // Message targets
  localparam logic [TargetW-1:0] TGT_CONST = 2'd0;
  localparam logic [TargetW-1:0] TGT_DC0   = 2'd1;
  localparam logic [TargetW-1:0] TGT_DC1   = 2'd2;

  // Operations
  localparam logic [OpW-1:0] OP_LOAD   = 5'd0;
  localparam logic [OpW-1:0] OP_STORE  = 5'd1;
  localparam logic [OpW-1:0] OP_ASTORE = 5'd2;
  localparam logic [OpW-1:0] OP_AND    = 5'd3;
  localparam logic [OpW-1:0] OP_XOR    = 5'd4;
  localparam logic [OpW-1:0] OP_OR     = 5'd5;
  localparam logic [OpW-1:0] OP_IADD   = 5'd6;
  localparam logic [OpW-1:0] OP_ISUB   = 5'd7;
  localparam logic [OpW-1:0] OP_IRSUB  = 5'd8;
  localparam logic [OpW-1:0] OP_ICAS   = 5'd9;
  localparam logic [OpW-1:0] OP_SMIN   = 5'd10;
  localparam logic [OpW-1:0] OP_SMAX   = 5'd11;
  localparam logic [OpW-1:0] OP_UMIN   = 5'd12;
  localparam logic [OpW-1:0] OP_UMAX   = 5'd13;
  localparam logic [OpW-1:0] OP_FMIN   = 5'd14;
  localparam logic [OpW-1:0] OP_FMAX   = 5'd15;
  localparam logic [OpW-1:0] OP_FCAS   = 5'd16;

  // Attribute flags
  localparam logic [AttrW-1:0] AT_SLM         = 7'h01;
  localparam logic [AttrW-1:0] AT_COHERENT    = 7'h02;
  localparam logic [AttrW-1:0] AT_TRANSPOSED  = 7'h04;
  localparam logic [AttrW-1:0] AT_EXPAND_HIGH = 7'h08;
  localparam logic [AttrW-1:0] AT_CHMASK      = 7'h10;
  localparam logic [AttrW-1:0] AT_ATOMIC_RET  = 7'h20;
  localparam logic [AttrW-1:0] AT_SCRATCH     = 7'h40;

  // Special binding table entries
  localparam logic [SurfW-1:0] BT_SLM         = 8'hFE;
  localparam logic [SurfW-1:0] BT_COHERENT    = 8'hFF;
  localparam logic [SurfW-1:0] BT_NONCOHERENT = 8'hFD;

  localparam logic [AddrW-1:0] ADDR_32 = 7'd32;
  localparam logic [AddrW-1:0] ADDR_64 = 7'd64;

  // Message type codes, descriptor bits 18:14
  localparam logic [MsgTypeW-1:0] MT_OW_RD0     = 5'h00;
  localparam logic [MsgTypeW-1:0] MT_OW_RD1     = 5'h01;
  localparam logic [MsgTypeW-1:0] MT_DW_RD      = 5'h03;
  localparam logic [MsgTypeW-1:0] MT_BYTE_RD    = 5'h04;
  localparam logic [MsgTypeW-1:0] MT_OW_WR0     = 5'h08;
  localparam logic [MsgTypeW-1:0] MT_OW_WR1     = 5'h09;
  localparam logic [MsgTypeW-1:0] MT_DW_WR      = 5'h0B;
  localparam logic [MsgTypeW-1:0] MT_BYTE_WR    = 5'h0C;
  localparam logic [MsgTypeW-1:0] MT_UNT_RD     = 5'h01;
  localparam logic [MsgTypeW-1:0] MT_INT_ATOM   = 5'h02;
  localparam logic [MsgTypeW-1:0] MT_UNT_WR     = 5'h09;
  localparam logic [MsgTypeW-1:0] MT_A64_SC_RD  = 5'h10;
  localparam logic [MsgTypeW-1:0] MT_A64_UNT_RD = 5'h11;
  localparam logic [MsgTypeW-1:0] MT_A64_ATOM   = 5'h12;
  localparam logic [MsgTypeW-1:0] MT_A64_BLK_RD = 5'h14;
  localparam logic [MsgTypeW-1:0] MT_A64_BLK_WR = 5'h15;
  localparam logic [MsgTypeW-1:0] MT_A64_UNT_WR = 5'h19;
  localparam logic [MsgTypeW-1:0] MT_A64_SC_WR  = 5'h1A;
  localparam logic [MsgTypeW-1:0] MT_FLT_ATOM   = 5'h1B;
  localparam logic [MsgTypeW-1:0] MT_A64_FATOM  = 5'h1D;

  // Message shape before the surface byte is resolved.
  typedef struct packed {
    logic              ok;
    logic [OpW-1:0]    op;
    logic [AddrW-1:0]  abits;
    logic [ElemW-1:0]  rbits;
    logic [ElemW-1:0]  mbits;
    logic [CountW-1:0] elems;
    logic [CountW-1:0] simd;
    logic [AttrW-1:0]  attrs;
    logic              rinv;
    logic [ImmW-1:0]   imm;
  } sdd_msg_t;

  // Final decoded message.
  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic              flat;
    logic [SurfW-1:0]  surf;
    logic              rinv;
    logic [AddrW-1:0]  abits;
    logic [ElemW-1:0]  rbits;
    logic [ElemW-1:0]  mbits;
    logic [CountW-1:0] elems;
    logic [CountW-1:0] simd;
    logic [AttrW-1:0]  attrs;
    logic [ImmW-1:0]   imm;
  } sdd_result_t;

endpackage

`default_nettype wire

// File: design/send_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// send_descriptor_decoder
// Decodes a send descriptor for its message target into a memory message.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) carries a target unit and a 32-bit
//   descriptor. The result channel (out_valid, out_stall) carries one decoded
//   message per input beat, in order. A descriptor that cannot be decoded
//   gives out_valid_res low with every other result field zero.
//   Each beat is captured in the input register, decoded by combinational
//   logic and captured in the result register. Throughput is one beat per
//   cycle while out_stall is low; the two registers form a two-deep pipeline.
//   While the receiver stalls, the result register holds its beat and the
//   input register may still take one more beat; in_stall rises only when
//   both registers are full and the output is stalled.
//   Reset empties both registers; no result is presented until a new beat.
// ----------------------------------------------------------------------------
`default_nettype none

module send_descriptor_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sdd_pkg::TargetW-1:0]  in_target_unit,
  input  wire logic [sdd_pkg::DescW-1:0]    in_descriptor,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_valid_res,
  output logic [sdd_pkg::OpW-1:0]           out_operation,
  output logic                              out_flat_addressing,
  output logic [sdd_pkg::SurfW-1:0]         out_surface_index,
  output logic                              out_read_invalidate,
  output logic [sdd_pkg::AddrW-1:0]         out_address_bits,
  output logic [sdd_pkg::ElemW-1:0]         out_register_element_bits,
  output logic [sdd_pkg::ElemW-1:0]         out_memory_element_bits,
  output logic [sdd_pkg::CountW-1:0]        out_elements_per_address,
  output logic [sdd_pkg::CountW-1:0]        out_exec_width,
  output logic [sdd_pkg::AttrW-1:0]         out_attribute_flags,
  output logic [sdd_pkg::ImmW-1:0]          out_immediate_offset
);
  import sdd_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  logic [TargetW-1:0] s1_target_r;
  logic [DescW-1:0]   s1_desc_r;
  logic               out_valid_r, out_valid_nxt;
  sdd_result_t        res_r;
  sdd_msg_t           msg;
  sdd_result_t        res;
  logic               out_adv;
  logic               in_adv;

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_adv   = !s1_valid_r || out_adv;
  assign in_stall = !in_adv;

  always_comb begin
    s1_valid_nxt  = in_adv ? in_valid : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      s1_target_r <= in_target_unit;
      s1_desc_r   <= in_descriptor;
    end
    if (out_adv) begin
      res_r <= res;
    end
  end

  sdd_msg_decode u_msg_decode (
    .target (s1_target_r),
    .desc   (s1_desc_r),
    .msg    (msg)
  );

  sdd_surface_resolve u_surface_resolve (
    .msg (msg),
    .bt  (s1_desc_r[SurfW-1:0]),
    .res (res)
  );

  assign out_valid                 = out_valid_r;
  assign out_valid_res             = res_r.valid;
  assign out_operation             = res_r.op;
  assign out_flat_addressing       = res_r.flat;
  assign out_surface_index         = res_r.surf;
  assign out_read_invalidate       = res_r.rinv;
  assign out_address_bits          = res_r.abits;
  assign out_register_element_bits = res_r.rbits;
  assign out_memory_element_bits   = res_r.mbits;
  assign out_elements_per_address  = res_r.elems;
  assign out_exec_width            = res_r.simd;
  assign out_attribute_flags       = res_r.attrs;
  assign out_immediate_offset      = res_r.imm;

  // The input side only backs up when both stages hold a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had room");

  // A failed decode carries no other information.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_operation == '0 && out_address_bits == '0 &&
      out_attribute_flags == '0 && out_immediate_offset == '0 && !out_flat_addressing))
    else $error("invalid result has non-zero fields");

  // Wide addresses are never surface indexed.
  a_wide_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res && out_address_bits == ADDR_64) |->
      (out_flat_addressing && out_surface_index == '0))
    else $error("64-bit message not flat");

  // A beat that leaves the input register reaches the output next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid)
    else $error("decoded beat lost");

endmodule

`default_nettype wire

// File: design/sdd_msg_decode.sv
// ----------------------------------------------------------------------------
// sdd_msg_decode
// Classifies the message type for the target and works out operation,
// element sizes, counts, SIMD width and attributes.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_msg_decode (
  input  wire logic [sdd_pkg::TargetW-1:0] target,
  input  wire logic [sdd_pkg::DescW-1:0]   desc,
  output sdd_pkg::sdd_msg_t                msg
);
  import sdd_pkg::*;

  logic [MsgTypeW-1:0] mt;
  logic [1:0]          ds;
  logic [CountW-1:0]   sm2;
  logic [CountW-1:0]   sm2h;
  logic [3:0]          ch_en;
  logic [CountW-1:0]   ch_count;
  logic [AttrW-1:0]    ret_attr;

  // Oword block access.
  function automatic sdd_msg_t ow_block(input logic [DescW-1:0] d, input logic [OpW-1:0] op,
                                        input logic [AddrW-1:0] ab);
    sdd_msg_t   m;
    logic [2:0] ow;
    ow       = d[10:8];
    m        = '0;
    m.ok     = (ow <= 3'd5);
    m.op     = op;
    m.abits  = ab;
    m.rbits  = (ow < 3'd2) ? 9'd256 : 9'd128;
    m.mbits  = 9'd128;
    m.elems  = (ow <= 3'd1) ? 5'd1 : (5'd1 << (ow - 3'd1));
    m.simd   = 5'd1;
    m.attrs  = AT_TRANSPOSED | ((ow == 3'd1) ? AT_EXPAND_HIGH : '0);
    return m;
  endfunction

  // Hword block access with the count code at a given place.
  function automatic sdd_msg_t hw_block(input logic [2:0] n, input logic [OpW-1:0] op,
                                        input logic [AddrW-1:0] ab, input logic [AttrW-1:0] at);
    sdd_msg_t m;
    m        = '0;
    m.ok     = (n <= 3'd4);
    m.op     = op;
    m.abits  = ab;
    m.rbits  = 9'd256;
    m.mbits  = 9'd256;
    m.elems  = 5'd1 << n;
    m.simd   = 5'd1;
    m.attrs  = at | AT_TRANSPOSED;
    return m;
  endfunction

  function automatic sdd_msg_t plain(input logic [OpW-1:0] op, input logic [AddrW-1:0] ab,
                                     input logic [ElemW-1:0] rb, input logic [ElemW-1:0] mb,
                                     input logic [CountW-1:0] el, input logic [CountW-1:0] sw,
                                     input logic [AttrW-1:0] at);
    sdd_msg_t m;
    m        = '0;
    m.ok     = 1'b1;
    m.op     = op;
    m.abits  = ab;
    m.rbits  = rb;
    m.mbits  = mb;
    m.elems  = el;
    m.simd   = sw;
    m.attrs  = at;
    return m;
  endfunction

  function automatic sdd_msg_t int_atomic(input logic [3:0] code, input logic [AddrW-1:0] ab,
                                          input logic [ElemW-1:0] db_in,
                                          input logic [CountW-1:0] sw,
                                          input logic [AttrW-1:0] ret);
    sdd_msg_t        m;
    logic [OpW-1:0]  op;
    logic [ElemW-1:0] db;
    logic            ok;
    db = db_in;
    ok = 1'b1;
    op = OP_LOAD;
    case (code)
      4'h0: begin
        op = OP_ICAS;
        db = 9'd64;
      end
      4'h1: op = OP_AND;
      4'h2: op = OP_OR;
      4'h3: op = OP_XOR;
      4'h4: op = OP_ASTORE;
      4'h7: op = OP_IADD;
      4'h8: op = OP_ISUB;
      4'h9: op = OP_IRSUB;
      4'hA: op = OP_SMAX;
      4'hB: op = OP_SMIN;
      4'hC: op = OP_UMAX;
      4'hD: op = OP_UMIN;
      4'hE: op = OP_ICAS;
      default: ok = 1'b0;
    endcase
    m    = plain(op, ab, db, db, 5'd1, sw, AT_CHMASK | ret);
    m.ok = ok;
    return m;
  endfunction

  function automatic sdd_msg_t float_atomic(input logic [2:0] code, input logic [AddrW-1:0] ab,
                                            input logic [CountW-1:0] sw,
                                            input logic [AttrW-1:0] ret);
    sdd_msg_t       m;
    logic [OpW-1:0] op;
    logic           ok;
    ok = 1'b1;
    op = OP_LOAD;
    case (code)
      3'h1: op = OP_FMAX;
      3'h2: op = OP_FMIN;
      3'h3: op = OP_FCAS;
      default: ok = 1'b0;
    endcase
    m    = plain(op, ab, 9'd32, 9'd32, 5'd1, sw, AT_CHMASK | ret);
    m.ok = ok;
    return m;
  endfunction

  assign mt       = desc[18:14];
  assign ds       = desc[11:10];
  assign sm2      = desc[8] ? 5'd16 : 5'd8;
  assign sm2h     = desc[12] ? 5'd16 : 5'd8;
  assign ch_en    = ~desc[11:8];
  assign ch_count = 5'(ch_en[0]) + 5'(ch_en[1]) + 5'(ch_en[2]) + 5'(ch_en[3]);
  assign ret_attr = desc[13] ? AT_ATOMIC_RET : '0;

  always_comb begin
    msg = '0;
    case (target)
      TGT_CONST: begin
        case (mt)
          MT_OW_RD0, MT_OW_RD1: msg = ow_block(desc, OP_LOAD, ADDR_32);
          MT_DW_RD: msg = plain(OP_LOAD, ADDR_32, 9'd32, 9'd32, 5'd1 << ds, sm2, '0);
          default: msg = '0;
        endcase
        msg.rinv = desc[13];
      end
      TGT_DC0: begin
        if (desc[18]) begin
          // Scratch block: the count sits higher, the low bits give the offset.
          msg     = hw_block(desc[14:12], desc[17] ? OP_LOAD : OP_STORE, ADDR_32, AT_SCRATCH);
          msg.imm = {desc[11:0], 5'd0};
        end else begin
          case (mt)
            MT_OW_RD0, MT_OW_RD1: msg = ow_block(desc, OP_LOAD, ADDR_32);
            MT_OW_WR0, MT_OW_WR1: msg = ow_block(desc, OP_STORE, ADDR_32);
            MT_DW_RD, MT_DW_WR: begin
              msg = plain((mt == MT_DW_RD) ? OP_LOAD : OP_STORE, ADDR_32, 9'd32, 9'd32,
                          5'd1 << ds, sm2, '0);
              msg.rinv = desc[13];
            end
            MT_BYTE_RD, MT_BYTE_WR: begin
              msg = plain((mt == MT_BYTE_RD) ? OP_LOAD : OP_STORE, ADDR_32, 9'd32,
                          9'd8 << ds, 5'd1, sm2, '0);
              msg.ok   = (ds != 2'd3);
              msg.rinv = desc[13];
            end
            default: msg = '0;
          endcase
        end
      end
      TGT_DC1: begin
        case (mt)
          MT_UNT_RD, MT_UNT_WR, MT_A64_UNT_RD, MT_A64_UNT_WR:
            msg = plain(mt[3] ? OP_STORE : OP_LOAD, mt[4] ? ADDR_64 : ADDR_32, 9'd32, 9'd32,
                        ch_count, (desc[13:12] == 2'd1) ? 5'd16 : 5'd8, AT_CHMASK);
          MT_A64_SC_RD, MT_A64_SC_WR: begin
            if (desc[9:8] == 2'd0) begin
              msg = plain((mt == MT_A64_SC_RD) ? OP_LOAD : OP_STORE, ADDR_64, 9'd32,
                          9'd8 << ds, 5'd1, sm2h, '0);
            end else begin
              msg = plain((mt == MT_A64_SC_RD) ? OP_LOAD : OP_STORE, ADDR_64,
                          (desc[9:8] == 2'd1) ? 9'd32 : 9'd64,
                          (desc[9:8] == 2'd1) ? 9'd32 : 9'd64, 5'd1 << ds, sm2h, '0);
            end
            msg.rinv = desc[13];
          end
          MT_A64_BLK_RD, MT_A64_BLK_WR: begin
            if (desc[12:11] == 2'd3) begin
              msg = hw_block(desc[10:8], (mt == MT_A64_BLK_RD) ? OP_LOAD : OP_STORE,
                             ADDR_64, '0);
            end else begin
              msg = ow_block(desc, (mt == MT_A64_BLK_RD) ? OP_LOAD : OP_STORE, ADDR_64);
            end
            msg.rinv = desc[13];
          end
          MT_A64_FATOM: msg = float_atomic(desc[10:8], ADDR_64,
                                           desc[12] ? 5'd8 : 5'd16, ret_attr);
          MT_FLT_ATOM:  msg = float_atomic(desc[10:8], ADDR_32,
                                           desc[12] ? 5'd8 : 5'd16, ret_attr);
          MT_A64_ATOM:  msg = int_atomic(desc[11:8], ADDR_64,
                                         desc[12] ? 9'd64 : 9'd32, 5'd8, ret_attr);
          MT_INT_ATOM:  msg = int_atomic(desc[11:8], ADDR_32, 9'd32,
                                         desc[12] ? 5'd8 : 5'd16, ret_attr);
          default: msg = '0;
        endcase
      end
      default: msg = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/sdd_surface_resolve.sv
// ----------------------------------------------------------------------------
// sdd_surface_resolve
// Resolves the binding table byte into flat or surface addressing and
// clears every field of a message that failed to decode.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_surface_resolve (
  input  wire sdd_pkg::sdd_msg_t           msg,
  input  wire logic [sdd_pkg::SurfW-1:0]   bt,
  output sdd_pkg::sdd_result_t             res
);
  import sdd_pkg::*;

  logic             flat;
  logic [SurfW-1:0] surf;
  logic [AttrW-1:0] attrs;
  logic             bt_ok;

  always_comb begin
    flat  = 1'b1;
    surf  = '0;
    attrs = msg.attrs;
    bt_ok = 1'b1;
    if (msg.abits == ADDR_32) begin
      if (bt == BT_SLM) begin
        attrs = attrs | AT_SLM;
      end else if (bt == BT_COHERENT) begin
        attrs = attrs | AT_COHERENT;
      end else if (bt != BT_NONCOHERENT) begin
        flat = 1'b0;
        surf = bt;
      end
    end else begin
      // Wide addresses are always flat and accept only the coherent and non-coherent codes.
      if (bt == BT_COHERENT) begin
        attrs = attrs | AT_COHERENT;
      end else if (bt != BT_NONCOHERENT) begin
        bt_ok = 1'b0;
      end
    end

    res = '0;
    if (msg.ok && bt_ok) begin
      res.valid = 1'b1;
      res.op    = msg.op;
      res.flat  = flat;
      res.surf  = surf;
      res.rinv  = msg.rinv;
      res.abits = msg.abits;
      res.rbits = msg.rbits;
      res.mbits = msg.mbits;
      res.elems = msg.elems;
      res.simd  = msg.simd;
      res.attrs = attrs;
      res.imm   = msg.imm;
    end
  end

endmodule

`default_nettype wire

// File: test/tb_send_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// tb_send_descriptor_decoder
// Self-checking regression for the send descriptor decoder. Each accepted
// input beat is decoded by a behavioural model in the testbench and queued;
// every result beat is compared field by field with the oldest queued entry.
// Directed beats cover the field extremes, the special surface bytes, the
// reserved encodings and every atomic opcode. Random beats, mostly built from
// supported message types, then run under random idling on both channels and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb_send_descriptor_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sdd_pkg::*;

  localparam logic [TargetW-1:0]  TGT_NONE  = 2'd3;
  // A data cache 0 type that the block does not support (a fence).
  localparam logic [MsgTypeW-1:0] MT_FENCE  = 5'h07;

  // Integer atomic opcodes, descriptor bits 11:8.
  localparam logic [3:0] IA_CAS64  = 4'h0;
  localparam logic [3:0] IA_AND    = 4'h1;
  localparam logic [3:0] IA_OR     = 4'h2;
  localparam logic [3:0] IA_XOR    = 4'h3;
  localparam logic [3:0] IA_MOV    = 4'h4;
  localparam logic [3:0] IA_ADD    = 4'h7;
  localparam logic [3:0] IA_SUB    = 4'h8;
  localparam logic [3:0] IA_REVSUB = 4'h9;
  localparam logic [3:0] IA_SMAX   = 4'hA;
  localparam logic [3:0] IA_SMIN   = 4'hB;
  localparam logic [3:0] IA_UMAX   = 4'hC;
  localparam logic [3:0] IA_UMIN   = 4'hD;
  localparam logic [3:0] IA_CAS    = 4'hE;

  // Float atomic opcodes, descriptor bits 10:8.
  localparam logic [2:0] FA_FMAX = 3'h1;
  localparam logic [2:0] FA_FMIN = 3'h2;
  localparam logic [2:0] FA_FCAS = 3'h3;

  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [1:0]  in_target_unit = '0;
  logic [31:0] in_descriptor  = '0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_valid_res;
  logic [4:0]  out_operation;
  logic        out_flat_addressing;
  logic [7:0]  out_surface_index;
  logic        out_read_invalidate;
  logic [6:0]  out_address_bits;
  logic [8:0]  out_register_element_bits;
  logic [8:0]  out_memory_element_bits;
  logic [4:0]  out_elements_per_address;
  logic [4:0]  out_exec_width;
  logic [6:0]  out_attribute_flags;
  logic [16:0] out_immediate_offset;

  sdd_result_t pending_decodes[$];
  int          error_count     = 0;
  int          cycle_count     = 0;
  bit          hold_off_request = 1'b0;

  send_descriptor_decoder u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_target_unit            (in_target_unit),
    .in_descriptor             (in_descriptor),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_valid_res             (out_valid_res),
    .out_operation             (out_operation),
    .out_flat_addressing       (out_flat_addressing),
    .out_surface_index         (out_surface_index),
    .out_read_invalidate       (out_read_invalidate),
    .out_address_bits          (out_address_bits),
    .out_register_element_bits (out_register_element_bits),
    .out_memory_element_bits   (out_memory_element_bits),
    .out_elements_per_address  (out_elements_per_address),
    .out_exec_width            (out_exec_width),
    .out_attribute_flags       (out_attribute_flags),
    .out_immediate_offset      (out_immediate_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural decoder
  // --------------------------------------------------------------------------

  // Resolves the surface byte and fills in the message; an illegal surface
  // byte for 64-bit addressing leaves the whole result cleared.
  function automatic sdd_result_t shape_message(logic [31:0] desc, logic [OpW-1:0] op,
                                                logic [AddrW-1:0] abits, int rbits,
                                                int mbits, int elems, int simd,
                                                logic [AttrW-1:0] flags);
    sdd_result_t r;
    logic [SurfW-1:0] bt;
    r  = '0;
    bt = desc[7:0];
    if (abits == ADDR_32) begin
      if (bt == BT_SLM) begin
        r.flat = 1'b1;
        flags  = flags | AT_SLM;
      end else if (bt == BT_COHERENT) begin
        r.flat = 1'b1;
        flags  = flags | AT_COHERENT;
      end else if (bt == BT_NONCOHERENT) begin
        r.flat = 1'b1;
      end else begin
        r.surf = bt;
      end
    end else begin
      r.flat = 1'b1;
      if (bt == BT_COHERENT) begin
        flags = flags | AT_COHERENT;
      end else if (bt != BT_NONCOHERENT) begin
        return '0;
      end
    end
    r.valid = 1'b1;
    r.op    = op;
    r.abits = abits;
    r.rbits = rbits[8:0];
    r.mbits = mbits[8:0];
    r.elems = elems[4:0];
    r.simd  = simd[4:0];
    r.attrs = flags;
    return r;
  endfunction

  function automatic sdd_result_t oword_block(logic [31:0] desc, logic [OpW-1:0] op,
                                              logic [AddrW-1:0] abits);
    logic [2:0]       count;
    logic [AttrW-1:0] flags;
    count = desc[10:8];
    flags = AT_TRANSPOSED;
    if (count > 3'd5) begin
      return '0;
    end
    if (count == 3'd1) begin
      flags = flags | AT_EXPAND_HIGH;
    end
    return shape_message(desc, op, abits, (count < 3'd2) ? 256 : 128, 128,
                         (count <= 3'd1) ? 1 : (1 << (count - 1)), 1, flags);
  endfunction

  function automatic sdd_result_t hword_block(logic [31:0] desc, logic [OpW-1:0] op,
                                              logic [AddrW-1:0] abits, int pos,
                                              logic [AttrW-1:0] flags);
    logic [2:0] count;
    count = 3'((desc >> pos) & 32'h7);
    if (count > 3'd4) begin
      return '0;
    end
    return shape_message(desc, op, abits, 256, 256, 1 << count, 1, flags | AT_TRANSPOSED);
  endfunction

  function automatic sdd_result_t int_atomic_msg(logic [31:0] desc, logic [AddrW-1:0] abits,
                                                 int data_bits, int simd);
    logic [OpW-1:0]   op;
    logic [AttrW-1:0] flags;
    flags = desc[13] ? (AT_CHMASK | AT_ATOMIC_RET) : AT_CHMASK;
    case (desc[11:8])
      IA_CAS64: begin
        op        = OP_ICAS;
        data_bits = 64;
      end
      IA_AND:    op = OP_AND;
      IA_OR:     op = OP_OR;
      IA_XOR:    op = OP_XOR;
      IA_MOV:    op = OP_ASTORE;
      IA_ADD:    op = OP_IADD;
      IA_SUB:    op = OP_ISUB;
      IA_REVSUB: op = OP_IRSUB;
      IA_SMAX:   op = OP_SMAX;
      IA_SMIN:   op = OP_SMIN;
      IA_UMAX:   op = OP_UMAX;
      IA_UMIN:   op = OP_UMIN;
      IA_CAS:    op = OP_ICAS;
      default:   return '0;
    endcase
    return shape_message(desc, op, abits, data_bits, data_bits, 1, simd, flags);
  endfunction

  function automatic sdd_result_t float_atomic_msg(logic [31:0] desc,
                                                   logic [AddrW-1:0] abits);
    logic [OpW-1:0]   op;
    logic [AttrW-1:0] flags;
    flags = desc[13] ? (AT_CHMASK | AT_ATOMIC_RET) : AT_CHMASK;
    case (desc[10:8])
      FA_FMAX: op = OP_FMAX;
      FA_FMIN: op = OP_FMIN;
      FA_FCAS: op = OP_FCAS;
      default: return '0;
    endcase
    return shape_message(desc, op, abits, 32, 32, 1, desc[12] ? 8 : 16, flags);
  endfunction

  function automatic sdd_result_t decode_descriptor(logic [TargetW-1:0] tgt,
                                                    logic [31:0] desc);
    sdd_result_t       r;
    logic [MsgTypeW-1:0] mt;
    logic [OpW-1:0]    op;
    logic [1:0]        ds;
    int                simd_lo;
    int                simd_hi;
    r       = '0;
    mt      = desc[18:14];
    ds      = desc[11:10];
    simd_lo = desc[8] ? 16 : 8;
    simd_hi = desc[12] ? 16 : 8;
    op      = OP_LOAD;
    case (tgt)
      TGT_CONST: begin
        if (mt == MT_OW_RD0 || mt == MT_OW_RD1) begin
          r = oword_block(desc, OP_LOAD, ADDR_32);
        end else if (mt == MT_DW_RD) begin
          r = shape_message(desc, OP_LOAD, ADDR_32, 32, 32, 1 << ds, simd_lo, '0);
        end
        r.rinv = desc[13];
      end
      TGT_DC0: begin
        if (desc[18]) begin
          // Scratch block: the low bits double as surface byte and offset.
          op    = desc[17] ? OP_LOAD : OP_STORE;
          r     = hword_block(desc, op, ADDR_32, 12, AT_SCRATCH);
          r.imm = 17'(32 * desc[11:0]);
        end else begin
          case (mt)
            MT_OW_RD0, MT_OW_RD1: r = oword_block(desc, OP_LOAD, ADDR_32);
            MT_OW_WR0, MT_OW_WR1: r = oword_block(desc, OP_STORE, ADDR_32);
            MT_DW_RD, MT_DW_WR: begin
              op     = (mt == MT_DW_RD) ? OP_LOAD : OP_STORE;
              r      = shape_message(desc, op, ADDR_32, 32, 32, 1 << ds, simd_lo, '0);
              r.rinv = desc[13];
            end
            MT_BYTE_RD, MT_BYTE_WR: begin
              if (ds != 2'd3) begin
                op     = (mt == MT_BYTE_RD) ? OP_LOAD : OP_STORE;
                r      = shape_message(desc, op, ADDR_32, 32, 8 << ds, 1, simd_lo, '0);
                r.rinv = desc[13];
              end
            end
            default: r = '0;
          endcase
        end
      end
      TGT_DC1: begin
        case (mt)
          MT_UNT_RD, MT_UNT_WR, MT_A64_UNT_RD, MT_A64_UNT_WR: begin
            op = mt[3] ? OP_STORE : OP_LOAD;
            r  = shape_message(desc, op, mt[4] ? ADDR_64 : ADDR_32, 32, 32,
                               $countones(~desc[11:8]),
                               (desc[13:12] == 2'd1) ? 16 : 8, AT_CHMASK);
          end
          MT_A64_SC_RD, MT_A64_SC_WR: begin
            op = (mt == MT_A64_SC_RD) ? OP_LOAD : OP_STORE;
            if (desc[9:8] == 2'd0) begin
              r = shape_message(desc, op, ADDR_64, 32, 8 << ds, 1, simd_hi, '0);
            end else if (desc[9:8] == 2'd1) begin
              r = shape_message(desc, op, ADDR_64, 32, 32, 1 << ds, simd_hi, '0);
            end else begin
              r = shape_message(desc, op, ADDR_64, 64, 64, 1 << ds, simd_hi, '0);
            end
            r.rinv = desc[13];
          end
          MT_A64_BLK_RD, MT_A64_BLK_WR: begin
            op = (mt == MT_A64_BLK_RD) ? OP_LOAD : OP_STORE;
            if (desc[12:11] == 2'd3) begin
              r = hword_block(desc, op, ADDR_64, 8, '0);
            end else begin
              r = oword_block(desc, op, ADDR_64);
            end
            r.rinv = desc[13];
          end
          MT_A64_FATOM: r = float_atomic_msg(desc, ADDR_64);
          MT_FLT_ATOM:  r = float_atomic_msg(desc, ADDR_32);
          MT_A64_ATOM:  r = int_atomic_msg(desc, ADDR_64, desc[12] ? 64 : 32, 8);
          MT_INT_ATOM:  r = int_atomic_msg(desc, ADDR_32, 32, desc[12] ? 8 : 16);
          default:      r = '0;
        endcase
      end
      default: r = '0;
    endcase
    if (!r.valid) begin
      r = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [31:0] compose_desc(logic [MsgTypeW-1:0] mt, logic [5:0] ctl,
                                               logic [7:0] bt);
    return {13'd0, mt, ctl, bt};
  endfunction

  // Mostly short idle stretches with the odd long one.
  function automatic int random_gap();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : random_gap();
  endfunction

  // Nine beats in ten use a supported message type with random content; the
  // rest are raw noise on any target.
  task automatic pick_random_beat(output logic [TargetW-1:0] tgt, output logic [31:0] desc);
    logic [MsgTypeW-1:0] mt;
    bit                  scratch;
    desc    = $urandom;
    tgt     = TGT_DC1;
    mt      = MT_UNT_RD;
    scratch = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      tgt = 2'($urandom_range(0, 3));
      return;
    end
    case ($urandom_range(0, 24))
      0:  begin tgt = TGT_CONST; mt = MT_OW_RD0;     end
      1:  begin tgt = TGT_CONST; mt = MT_OW_RD1;     end
      2:  begin tgt = TGT_CONST; mt = MT_DW_RD;      end
      3:  begin tgt = TGT_DC0;   mt = MT_OW_RD0;     end
      4:  begin tgt = TGT_DC0;   mt = MT_OW_RD1;     end
      5:  begin tgt = TGT_DC0;   mt = MT_OW_WR0;     end
      6:  begin tgt = TGT_DC0;   mt = MT_OW_WR1;     end
      7:  begin tgt = TGT_DC0;   mt = MT_DW_RD;      end
      8:  begin tgt = TGT_DC0;   mt = MT_DW_WR;      end
      9:  begin tgt = TGT_DC0;   mt = MT_BYTE_RD;    end
      10: begin tgt = TGT_DC0;   mt = MT_BYTE_WR;    end
      11, 12: begin
        tgt     = TGT_DC0;
        scratch = 1'b1;
      end
      13: mt = MT_UNT_RD;
      14: mt = MT_UNT_WR;
      15: mt = MT_A64_UNT_RD;
      16: mt = MT_A64_UNT_WR;
      17: mt = MT_A64_SC_RD;
      18: mt = MT_A64_SC_WR;
      19: mt = MT_A64_BLK_RD;
      20: mt = MT_A64_BLK_WR;
      21: mt = MT_A64_FATOM;
      22: mt = MT_FLT_ATOM;
      23: mt = MT_A64_ATOM;
      default: mt = MT_INT_ATOM;
    endcase
    if (scratch) begin
      desc[18] = 1'b1;
    end else begin
      desc[18:14] = mt;
    end
    // Favour the special surface bytes so that flat addressing is common.
    case ($urandom_range(0, 7))
      0:       desc[7:0] = BT_SLM;
      1, 2:    desc[7:0] = BT_COHERENT;
      3, 4:    desc[7:0] = BT_NONCOHERENT;
      5:       desc[7:0] = 8'h00;
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [TargetW-1:0] tgt, input logic [31:0] desc,
                           input int gap);
    in_valid       <= 1'b1;
    in_target_unit <= tgt;
    in_descriptor  <= desc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_decodes.push_back(decode_descriptor(tgt, desc));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender pauses until every queued decode has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_target_extremes();
    send_beat(TGT_NONE, 32'hFFFF_FFFF, 0);
    send_beat(TGT_CONST, 32'h0000_0000, 1);
    send_beat(TGT_DC1, 32'hFFFF_FFFF, 0);
  endtask

  // With 64-bit addressing only the coherent and non-coherent bytes are legal.
  task automatic test_surface_byte();
    send_beat(TGT_DC1, compose_desc(MT_A64_SC_RD, 6'b10_1101, BT_NONCOHERENT), 0);
    send_beat(TGT_DC1, compose_desc(MT_A64_SC_WR, 6'b00_0000, 8'h00), 2);
  endtask

  task automatic test_reserved_encodings();
    logic [31:0] scratch_max;
    logic [31:0] scratch_bad;
    scratch_max        = '0;
    scratch_max[18:17] = 2'b11;
    scratch_max[14:12] = 3'd4;
    scratch_max[11:0]  = 12'hFFF;
    scratch_bad        = '0;
    scratch_bad[18]    = 1'b1;
    scratch_bad[14:12] = 3'd5;
    send_beat(TGT_DC0, scratch_max, 0);
    send_beat(TGT_DC0, scratch_bad, 0);
    send_beat(TGT_DC0, compose_desc(MT_OW_WR0, 6'b00_0110, 8'h10), 1);
    send_beat(TGT_DC0, compose_desc(MT_BYTE_RD, 6'b00_1100, 8'h01), 0);
    // All four channels masked off still decodes, with no elements.
    send_beat(TGT_DC1, compose_desc(MT_UNT_RD, 6'b01_1111, BT_SLM), 0);
    send_beat(TGT_DC0, compose_desc(MT_FENCE, 6'b00_0000, 8'h00), 3);
  endtask

  // Every integer opcode, legal or not, with the surface byte cycling
  // through the special values and a plain index; then each float opcode.
  task automatic test_atomic_opcodes();
    logic [7:0] bt;
    for (int code = 0; code < 16; code++) begin
      case (code % 4)
        0:       bt = BT_SLM;
        1:       bt = BT_COHERENT;
        2:       bt = BT_NONCOHERENT;
        default: bt = 8'h5A;
      endcase
      send_beat(TGT_DC1, compose_desc(MT_INT_ATOM, {code[0], code[1], code[3:0]}, bt),
                code[2] ? 1 : 0);
    end
    send_beat(TGT_DC1, compose_desc(MT_A64_FATOM, {3'b010, FA_FMAX}, BT_COHERENT), 0);
    send_beat(TGT_DC1, compose_desc(MT_FLT_ATOM, {3'b000, FA_FMIN}, 8'h22), 0);
    send_beat(TGT_DC1, compose_desc(MT_A64_FATOM, {3'b100, FA_FCAS}, BT_NONCOHERENT), 0);
  endtask

  task automatic test_random_mix(input int count);
    logic [TargetW-1:0] tgt;
    logic [31:0]        desc;
    for (int i = 0; i < count; i++) begin
      pick_random_beat(tgt, desc);
      send_beat(tgt, desc, sender_gap());
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the pipeline fills and the input stalls.
  task automatic test_output_backpressure(input int count);
    logic [TargetW-1:0] tgt;
    logic [31:0]        desc;
    hold_off_request = 1'b1;
    for (int i = 0; i < count; i++) begin
      pick_random_beat(tgt, desc);
      send_beat(tgt, desc, 0);
    end
  endtask

  task automatic test_random_bursts(input int count);
    logic [TargetW-1:0] tgt;
    logic [31:0]        desc;
    for (int i = 0; i < count; i++) begin
      pick_random_beat(tgt, desc);
      send_beat(tgt, desc, ($urandom_range(0, 29) == 0) ? random_gap() : 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      error_count++;
    end
  endfunction

  initial begin : result_checker
    sdd_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          $error("result beat with no decode outstanding");
          error_count++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("valid_res", want.valid, out_valid_res);
          check_field("operation", want.op, out_operation);
          check_field("flat_addressing", want.flat, out_flat_addressing);
          check_field("surface_index", want.surf, out_surface_index);
          check_field("read_invalidate", want.rinv, out_read_invalidate);
          check_field("address_bits", want.abits, out_address_bits);
          check_field("register_element_bits", want.rbits, out_register_element_bits);
          check_field("memory_element_bits", want.mbits, out_memory_element_bits);
          check_field("elements_per_address", want.elems, out_elements_per_address);
          check_field("exec_width", want.simd, out_exec_width);
          check_field("attribute_flags", want.attrs, out_attribute_flags);
          check_field("immediate_offset", want.imm, out_immediate_offset);
        end
      end
    end
  end

  // Receiver idling: random stalls, calm stretches, and a long hold-off when
  // the back-pressure test asks for one.
  initial begin : receiver_stalls
    int stall_left;
    int calm_left;
    int hold_left;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left        = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        case ($urandom_range(0, 9))
          0:       calm_left  = $urandom_range(20, 80);
          1, 2, 3: stall_left = random_gap();
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("send_descriptor_decoder regression: fail");
        $finish;
      end
    end
  end

  initial begin : main_sequence
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_target_extremes();
    test_surface_byte();
    test_reserved_encodings();
    test_atomic_opcodes();
    wait_for_results();
    test_random_mix(560);
    wait_for_results();
    test_output_backpressure(60);
    wait_for_results();
    test_random_bursts(230);
    wait_for_results();
    // Any stray beat after the last expected one would show up here.
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("send_descriptor_decoder regression: pass");
    end else begin
      $display("send_descriptor_decoder regression: fail");
    end
    $finish;
  end

endmodule
